// ===== rtl/ptq_pkg.sv =====
// Shared types and constants for the periodic task timer queue.
package ptq_pkg;
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  task_id;
        logic [23:0] start_delay;
        logic [23:0] interval;
    } t_item;

    typedef struct packed {
        logic       fired_valid;
        logic [7:0] fired_task;
        logic [1:0] status;
        logic       last;
    } t_result;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // capture the input item
        logic adv_time;   // add tick step to the clock
        logic scan_init;  // reset the slot pointer
        logic scan_step;  // advance the slot pointer
        logic do_insert;  // write pending entry at the pointer, shift tail up
        logic do_delete;  // drop entry at the pointer, shift tail down
        logic fire_push;  // take head into the fired list
        logic rearm_init; // reset the fired list read pointer
        logic rearm_next; // load the next fired entry as pending insert
        logic emit_init;
        logic emit_next;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic [1:0] action;
        logic       full;
        logic       scan_end;   // pointer reached the fill count
        logic       ins_here;   // slot at the pointer is due later than pending
        logic       tag_hit;
        logic       head_due;
        logic       fired_full;
        logic       rearm_end;
        logic       rearm_ok;   // current fired entry is periodic and room exists
        logic       fired_none;
        logic       emit_last;
    } t_stat;
endpackage

// ===== rtl/ptq_datapath.sv =====
// Datapath of the timer queue: slot storage, clock, fired list and result.
module ptq_datapath #(
    parameter int MAX_TASKS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ptq_pkg::t_item  i_item,
    input  logic [3:0]      i_tick_seconds,
    input  ptq_pkg::t_cmd   i_cmd,
    output ptq_pkg::t_stat  o_stat,
    output ptq_pkg::t_result o_result
);
    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    logic [31:0] r_dl  [MAX_TASKS];
    logic [23:0] r_per [MAX_TASKS];
    logic [7:0]  r_tag [MAX_TASKS];
    logic [23:0] r_fper [MAX_TASKS];
    logic [7:0]  r_ftag [MAX_TASKS];
    logic [CW-1:0] r_count, r_ptr, r_nf, r_rp;
    logic [31:0] r_time;
    ptq_pkg::t_item r_item;
    logic [23:0] r_pdelay, r_pper;
    logic [7:0]  r_ptag;
    logic [3:0]  r_step;

    logic [IW-1:0] w_pi, w_ri;
    logic [31:0]   w_rem_ins, w_rem_head;
    logic [3:0]    w_step;

    assign w_pi = r_ptr[IW-1:0];
    assign w_ri = r_rp[IW-1:0];
    assign w_rem_ins  = r_dl[w_pi] - r_time;
    assign w_rem_head = r_dl[0] - r_time;
    assign w_step = (i_tick_seconds == 4'd1 || i_tick_seconds == 4'd2 ||
                     i_tick_seconds == 4'd4 || i_tick_seconds == 4'd8) ?
                    i_tick_seconds : 4'd1;

    always_comb begin
        o_stat.action     = r_item.action;
        o_stat.full       = (r_count >= CW'(MAX_TASKS));
        o_stat.scan_end   = (r_ptr >= r_count);
        o_stat.ins_here   = (w_rem_ins > {8'd0, r_pdelay});
        o_stat.tag_hit    = (r_tag[w_pi] == r_item.task_id);
        o_stat.head_due   = (r_count != '0) &&
                            ((w_rem_head == 32'd0) || w_rem_head[31]);
        o_stat.fired_full = (r_nf >= CW'(MAX_TASKS));
        o_stat.rearm_end  = (r_rp >= r_nf);
        o_stat.rearm_ok   = (r_fper[w_ri] != 24'd0) && (r_count < CW'(MAX_TASKS));
        o_stat.fired_none = (r_nf == '0);
        o_stat.emit_last  = (r_rp + CW'(1) >= r_nf);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_time  <= '0;
            r_ptr   <= '0;
            r_nf    <= '0;
            r_rp    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_item   <= i_item;
                r_pdelay <= (i_item.start_delay != 24'd0) ? i_item.start_delay
                                                          : i_item.interval;
                r_pper   <= i_item.interval;
                r_ptag   <= i_item.task_id;
                r_nf     <= '0;
                r_step   <= w_step;
            end
            if (i_cmd.adv_time) r_time <= r_time + {28'd0, r_step};
            if (i_cmd.scan_init) r_ptr <= '0;
            if (i_cmd.scan_step) r_ptr <= r_ptr + CW'(1);
            if (i_cmd.do_insert) begin
                for (int i = MAX_TASKS - 1; i > 0; i--) begin
                    if (CW'(i) > r_ptr && CW'(i) <= r_count) begin
                        r_dl[i]  <= r_dl[i-1];
                        r_per[i] <= r_per[i-1];
                        r_tag[i] <= r_tag[i-1];
                    end
                end
                r_dl[w_pi]  <= r_time + {8'd0, r_pdelay};
                r_per[w_pi] <= r_pper;
                r_tag[w_pi] <= r_ptag;
                r_count     <= r_count + CW'(1);
            end
            if (i_cmd.do_delete) begin
                for (int i = 0; i < MAX_TASKS - 1; i++) begin
                    if (CW'(i) >= r_ptr) begin
                        r_dl[i]  <= r_dl[i+1];
                        r_per[i] <= r_per[i+1];
                        r_tag[i] <= r_tag[i+1];
                    end
                end
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.fire_push) begin
                r_ftag[r_nf[IW-1:0]] <= r_tag[0];
                r_fper[r_nf[IW-1:0]] <= r_per[0];
                r_nf <= r_nf + CW'(1);
            end
            if (i_cmd.rearm_init || i_cmd.emit_init) r_rp <= '0;
            if (i_cmd.rearm_next || i_cmd.emit_next) r_rp <= r_rp + CW'(1);
            if (i_cmd.rearm_next) begin
                r_pdelay <= r_fper[w_ri];
                r_pper   <= r_fper[w_ri];
                r_ptag   <= r_ftag[w_ri];
            end
        end
    end

    assign o_result.fired_valid = 1'b0;
    assign o_result.fired_task  = r_ftag[w_ri];
    assign o_result.status      = ptq_pkg::ST_OK;
    assign o_result.last        = o_stat.emit_last;
endmodule

// ===== rtl/ptq_ctrl.sv =====
// Controller state machine of the timer queue.
module ptq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  ptq_pkg::t_stat    i_stat,
    input  ptq_pkg::t_result  i_dp_result,
    output ptq_pkg::t_cmd     o_cmd,
    output ptq_pkg::t_result  o_result
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_INS     = 4'd2;
    localparam logic [3:0] S_REM     = 4'd3;
    localparam logic [3:0] S_FIRE    = 4'd4;
    localparam logic [3:0] S_RLOAD   = 4'd5;
    localparam logic [3:0] S_RINS    = 4'd6;
    localparam logic [3:0] S_EMIT    = 4'd7;
    localparam logic [3:0] S_OUT     = 4'd8;
    localparam logic [3:0] S_RSCAN   = 4'd9;

    logic [3:0] r_state, n_state;
    ptq_pkg::t_result r_res, n_res;
    logic r_ov, n_ov;

    assign o_in_ready  = (r_state == S_IDLE) && !r_ov;
    assign o_out_valid = r_ov;
    assign o_result    = r_res;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_res   = r_res;
        n_ov    = r_ov && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.scan_init = 1'b1;
                n_res = '{fired_valid: 1'b0, fired_task: 8'd0,
                          status: ptq_pkg::ST_OK, last: 1'b1};
                priority if (i_stat.action == ptq_pkg::ACT_ADD) begin
                    if (i_stat.full) begin
                        n_res.status = ptq_pkg::ST_FULL;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_INS;
                    end
                end else if (i_stat.action == ptq_pkg::ACT_TICK) begin
                    o_cmd.adv_time = 1'b1;
                    n_state = S_FIRE;
                end else if (i_stat.action == ptq_pkg::ACT_REMOVE) begin
                    n_state = S_REM;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_INS, S_RSCAN: begin
                if (i_stat.scan_end || i_stat.ins_here) begin
                    o_cmd.do_insert = 1'b1;
                    if (r_state == S_INS) n_state = S_OUT;
                    else n_state = S_RLOAD;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_REM: begin
                if (i_stat.scan_end) begin
                    n_res.status = ptq_pkg::ST_NOT_FOUND;
                    n_state = S_OUT;
                end else if (i_stat.tag_hit) begin
                    o_cmd.do_delete = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_FIRE: begin
                if (i_stat.head_due && !i_stat.fired_full) begin
                    o_cmd.fire_push = 1'b1;
                    o_cmd.do_delete = 1'b1;
                end else begin
                    o_cmd.rearm_init = 1'b1;
                    n_state = S_RLOAD;
                end
            end
            S_RLOAD: begin
                o_cmd.scan_init = 1'b1;
                if (i_stat.rearm_end) begin
                    o_cmd.emit_init = 1'b1;
                    n_state = i_stat.fired_none ? S_OUT : S_EMIT;
                end else begin
                    o_cmd.rearm_next = 1'b1;
                    n_state = i_stat.rearm_ok ? S_RSCAN : S_RLOAD;
                end
            end
            S_EMIT: begin
                if (!r_ov || i_out_ready) begin
                    n_ov = 1'b1;
                    n_res.fired_valid = 1'b1;
                    n_res.fired_task  = i_dp_result.fired_task;
                    n_res.status      = ptq_pkg::ST_OK;
                    n_res.last        = i_dp_result.last;
                    o_cmd.emit_next   = 1'b1;
                    if (i_dp_result.last) n_state = S_IDLE;
                end
            end
            S_OUT: begin
                n_ov = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_res <= n_res;
    end
endmodule

// ===== rtl/periodic_task_timer_queue.sv =====
// Top level of the periodic task timer queue.
// channel  | dir | handshake                 | payload
// s_axis   | in  | s_axis_tvalid/tready      | tdata: action,task_id,start_delay,interval
// m_axis   | out | m_axis_tvalid/tready      | tdata: fired_valid,fired_task,status; tlast
// cfg      | in  | i_cfg_valid/o_cfg_ready   | tick_seconds
// Add and remove walk the slot array one slot a cycle.
// A tick advances the clock, fires the due heads, re-inserts the periodic ones, then emits each fired result.
// Reset clears the count, clock and controller; slot contents stay unwritten.
// A stalled output holds the controller; one item is in work at a time.
module periodic_task_timer_queue #(
    parameter int MAX_TASKS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // action[1:0], task_id, start_delay, interval
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // fired_valid, fired_task, status, zero fill
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);
    ptq_pkg::t_item   w_item;
    ptq_pkg::t_cmd    w_cmd;
    ptq_pkg::t_stat   w_stat;
    ptq_pkg::t_result w_dp_res, w_res;
    logic [3:0] r_tick;

    assign w_item.action      = s_axis_tdata[1:0];
    assign w_item.task_id     = s_axis_tdata[9:2];
    assign w_item.start_delay = s_axis_tdata[33:10];
    assign w_item.interval    = s_axis_tdata[57:34];

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= 4'd1;
        end else if (i_cfg_valid) begin
            r_tick <= i_cfg_data;
        end
    end

    ptq_datapath #(.MAX_TASKS(MAX_TASKS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(w_item),
        .i_tick_seconds(r_tick), .i_cmd(w_cmd), .o_stat(w_stat),
        .o_result(w_dp_res)
    );

    ptq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_stat(w_stat), .i_dp_result(w_dp_res), .o_cmd(w_cmd), .o_result(w_res)
    );

    assign m_axis_tdata = {5'd0, w_res.status, w_res.fired_task, w_res.fired_valid};
    assign m_axis_tlast = w_res.last;
endmodule
